FILE: src/nmsbd_pkg.sv
package nmsbd_pkg;

	localparam int FRAC_BITS     = 12;
	localparam int WORD_W        = 24;
	localparam int SIZE_W        = 13;
	localparam int PIX_W         = 12;
	localparam int CLASS_W       = 8;
	localparam int POS_W         = 3;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;
	localparam int COORD_N       = 4;
	localparam int WORDS_PER_BOX = 5;
	localparam int MAX_SIZE      = 4096;
	localparam int PROD_W        = WORD_W + SIZE_W + 1;

	localparam logic [SIZE_W-1:0]  MAX_SIZE_V   = SIZE_W'(MAX_SIZE);
	localparam logic [CLASS_W-1:0] MAX_COUNT    = '1;
	localparam logic [POS_W-1:0]   LAST_COORD   = POS_W'(WORDS_PER_BOX - 2);

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_WIDTH  = 2'd0,
		CFG_TARGET_HEIGHT = 2'd1,
		CFG_SCORE_LIMIT   = 2'd2,
		CFG_CLASS_TOTAL   = 2'd3
	} cfg_idx_t;

	// held coordinate slots, in stream order
	typedef enum logic [1:0] {
		CRD_YMIN = 2'd0,
		CRD_XMIN = 2'd1,
		CRD_YMAX = 2'd2,
		CRD_XMAX = 2'd3
	} coord_idx_t;

	typedef struct packed {
		logic                     kept;
		logic [CLASS_W-1:0]       class_num;
		logic [PIX_W-1:0]         left_x;
		logic [PIX_W-1:0]         top_y;
		logic [PIX_W-1:0]         right_x;
		logic [PIX_W-1:0]         bottom_y;
		logic signed [WORD_W-1:0] score;
		logic                     frame_end;
	} result_t;

	// per-word decision from the parser
	typedef struct packed {
		logic               is_score;
		logic               score_ok;
		logic               frame_end;
		logic [CLASS_W-1:0] class_num;
	} parse_t;

endpackage

FILE: src/nmsbd_word_if.sv
interface nmsbd_word_if;
	logic                              valid;
	logic                              ready;
	logic signed [nmsbd_pkg::WORD_W-1:0] word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

FILE: src/nmsbd_result_if.sv
interface nmsbd_result_if;
	logic                 valid;
	logic                 ready;
	nmsbd_pkg::result_t   res;

	modport source (output valid, output res, input ready);
	modport sink (input valid, input res, output ready);
endinterface

FILE: src/nmsbd_pixel.sv
module nmsbd_pixel (
	input  logic signed [nmsbd_pkg::WORD_W-1:0] coord,
	input  logic [nmsbd_pkg::SIZE_W-1:0]        size_reg,
	output logic [nmsbd_pkg::PIX_W-1:0]         pix
);

	localparam logic signed [nmsbd_pkg::WORD_W-1:0] LIMIT =
		nmsbd_pkg::WORD_W'(3 << (nmsbd_pkg::FRAC_BITS - 1));

	logic [nmsbd_pkg::SIZE_W-1:0]        size;
	logic [nmsbd_pkg::SIZE_W-1:0]        size_m1;
	logic signed [nmsbd_pkg::PROD_W-1:0] prod;
	logic signed [nmsbd_pkg::PROD_W-1:0] val;
	logic signed [nmsbd_pkg::PROD_W-1:0] max_v;

	always_comb begin
		size    = (size_reg > nmsbd_pkg::MAX_SIZE_V) ? nmsbd_pkg::MAX_SIZE_V : size_reg;
		size_m1 = size - nmsbd_pkg::SIZE_W'(1);
		prod    = nmsbd_pkg::PROD_W'(coord) *
			$signed({{(nmsbd_pkg::PROD_W-nmsbd_pkg::SIZE_W){1'b0}}, size});
		// floor vs. truncation only differs below zero, which clamps to 0 anyway
		if (coord <= LIMIT)
			val = prod >>> nmsbd_pkg::FRAC_BITS;
		else
			val = nmsbd_pkg::PROD_W'(coord) >>> nmsbd_pkg::FRAC_BITS;
		max_v = $signed({{(nmsbd_pkg::PROD_W-nmsbd_pkg::SIZE_W){1'b0}}, size_m1});

		if (size == '0 || val < 0)
			pix = '0;
		else if (val > max_v)
			pix = size_m1[nmsbd_pkg::PIX_W-1:0];
		else
			pix = val[nmsbd_pkg::PIX_W-1:0];
	end

endmodule

FILE: src/nmsbd_parser.sv
module nmsbd_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic signed [nmsbd_pkg::WORD_W-1:0] word,
	input  logic [nmsbd_pkg::SIZE_W-1:0]        score_limit,
	input  logic [nmsbd_pkg::CLASS_W-1:0]       class_total,
	output nmsbd_pkg::parse_t                   info,
	output logic signed [nmsbd_pkg::WORD_W-1:0] coords [nmsbd_pkg::COORD_N]
);

	logic [nmsbd_pkg::CLASS_W-1:0] class_q;
	logic                          expect_q;
	logic [nmsbd_pkg::CLASS_W-1:0] boxes_q;
	logic [nmsbd_pkg::POS_W-1:0]   pos_q;
	logic signed [nmsbd_pkg::WORD_W-1:0] coord_q [nmsbd_pkg::COORD_N];

	logic [nmsbd_pkg::WORD_W-1:0]  shifted;
	logic [nmsbd_pkg::CLASS_W-1:0] cnt;
	logic [nmsbd_pkg::CLASS_W-1:0] total;
	logic [nmsbd_pkg::CLASS_W-1:0] class_inc;
	logic                          wrap;
	logic [nmsbd_pkg::CLASS_W-1:0] boxes_dec;
	logic                          class_done;
	logic                          is_count;
	logic                          is_coord;

	always_comb begin
		shifted = $unsigned(word) >> nmsbd_pkg::FRAC_BITS;
		if (word <= 0)
			cnt = '0;
		else if (|shifted[nmsbd_pkg::WORD_W-1:nmsbd_pkg::CLASS_W])
			cnt = nmsbd_pkg::MAX_COUNT;
		else
			cnt = shifted[nmsbd_pkg::CLASS_W-1:0];

		total     = (class_total == '0) ? nmsbd_pkg::CLASS_W'(1) : class_total;
		class_inc = class_q + nmsbd_pkg::CLASS_W'(1);
		wrap      = class_inc >= total;
		boxes_dec = (boxes_q != '0) ? boxes_q - nmsbd_pkg::CLASS_W'(1) : boxes_q;

		is_count      = expect_q;
		is_coord      = !expect_q && pos_q < nmsbd_pkg::LAST_COORD + nmsbd_pkg::POS_W'(1);
		info.is_score = !expect_q && !is_coord;
		info.score_ok = word >= $signed({{(nmsbd_pkg::WORD_W-nmsbd_pkg::SIZE_W){1'b0}},
			score_limit});
		class_done    = (is_count && cnt == '0) || (info.is_score && boxes_dec == '0);
		info.frame_end = class_done && wrap;
		info.class_num = class_q;
	end

	always_comb begin
		for (int i = 0; i < nmsbd_pkg::COORD_N; i++)
			coords[i] = coord_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q  <= '0;
			expect_q <= 1'b1;
			boxes_q  <= '0;
			pos_q    <= '0;
			for (int i = 0; i < nmsbd_pkg::COORD_N; i++)
				coord_q[i] <= '0;
		end else if (step) begin
			if (class_done) begin
				class_q  <= wrap ? '0 : class_inc;
				expect_q <= 1'b1;
				boxes_q  <= '0;
				pos_q    <= '0;
			end else if (is_count) begin
				boxes_q  <= cnt;
				expect_q <= 1'b0;
				pos_q    <= '0;
			end else if (is_coord) begin
				coord_q[pos_q[1:0]] <= word;
				pos_q <= pos_q + nmsbd_pkg::POS_W'(1);
			end else begin
				// score word, more boxes to come in this class
				boxes_q <= boxes_dec;
				pos_q   <= '0;
			end
		end
	end

endmodule

FILE: src/nms_by_class_box_decoder.sv
// Per-class detection list decoder.
// Channel in carries one detector output word per transfer (signed, Q11.12).
// Per class the stream holds a box count, then ymin, xmin, ymax, xmax, score
// for each box. Channel out carries one result per kept box, plus one on the
// word that completes the last class of the frame (frame_end set; kept may
// be 0, then all other fields are 0).
// Configuration: cfg_we/cfg_index/cfg_data write target_width (0),
// target_height (1), score_limit (2) and class_total (3); write while idle.
// A word is registered in the input register at acceptance and its result is
// registered in the result register when the word moves on, so out.valid rises
// once the result of the score word is held in the result register.
// Throughput: one word per cycle while out does not stall; the path from input
// register to result register is one 24x13 multiply and clamp per coordinate.
// When out stalls, the result register holds and one more word may wait in
// the input register; in.ready drops only when both are full.
// Reset (arst_n low) restores register defaults (640, 640, 2048, 80) and
// starts at class 0 awaiting a count word.
module nms_by_class_box_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	nmsbd_word_if.sink                          in,
	nmsbd_result_if.source                      out,
	input  logic                                cfg_we,
	input  logic [nmsbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nmsbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [nmsbd_pkg::SIZE_W-1:0]  width_q;
	logic [nmsbd_pkg::SIZE_W-1:0]  height_q;
	logic [nmsbd_pkg::SIZE_W-1:0]  limit_q;
	logic [nmsbd_pkg::CLASS_W-1:0] total_q;

	logic                                valid_s1;
	logic signed [nmsbd_pkg::WORD_W-1:0] word_s1;
	logic                                out_valid_q;
	nmsbd_pkg::result_t                  res_q;

	logic                                advance;
	logic                                produce;
	logic                                box_ok;
	nmsbd_pkg::parse_t                   info;
	nmsbd_pkg::result_t                  res_d;
	logic signed [nmsbd_pkg::WORD_W-1:0] coords [nmsbd_pkg::COORD_N];
	logic [nmsbd_pkg::PIX_W-1:0]         x1, y1, x2, y2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= nmsbd_pkg::SIZE_W'(640);
			height_q <= nmsbd_pkg::SIZE_W'(640);
			limit_q  <= nmsbd_pkg::SIZE_W'(2048);
			total_q  <= nmsbd_pkg::CLASS_W'(80);
		end else if (cfg_we) begin
			unique case (nmsbd_pkg::cfg_idx_t'(cfg_index))
				nmsbd_pkg::CFG_TARGET_WIDTH:  width_q  <= cfg_data;
				nmsbd_pkg::CFG_TARGET_HEIGHT: height_q <= cfg_data;
				nmsbd_pkg::CFG_SCORE_LIMIT:   limit_q  <= cfg_data;
				nmsbd_pkg::CFG_CLASS_TOTAL:   total_q  <= cfg_data[nmsbd_pkg::CLASS_W-1:0];
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out.ready);
	assign in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in.ready)
			valid_s1 <= in.valid;
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid)
			word_s1 <= in.word;
	end

	nmsbd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.word        (word_s1),
		.score_limit (limit_q),
		.class_total (total_q),
		.info        (info),
		.coords      (coords)
	);

	nmsbd_pixel u_pix_y1 (.coord(coords[nmsbd_pkg::CRD_YMIN]), .size_reg(height_q), .pix(y1));
	nmsbd_pixel u_pix_x1 (.coord(coords[nmsbd_pkg::CRD_XMIN]), .size_reg(width_q),  .pix(x1));
	nmsbd_pixel u_pix_y2 (.coord(coords[nmsbd_pkg::CRD_YMAX]), .size_reg(height_q), .pix(y2));
	nmsbd_pixel u_pix_x2 (.coord(coords[nmsbd_pkg::CRD_XMAX]), .size_reg(width_q),  .pix(x2));

	always_comb begin
		box_ok  = info.is_score && info.score_ok && x2 > x1 && y2 > y1;
		produce = box_ok || info.frame_end;
		res_d   = '0;
		res_d.frame_end = info.frame_end;
		if (box_ok) begin
			res_d.kept      = 1'b1;
			res_d.class_num = info.class_num;
			res_d.left_x    = x1;
			res_d.top_y     = y1;
			res_d.right_x   = x2;
			res_d.bottom_y  = y2;
			res_d.score     = word_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= produce;
		else if (out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && produce)
			res_q <= res_d;
	end

	assign out.valid = out_valid_q;
	assign out.res   = res_q;

endmodule

FILE: src/nmsbd_checker.sv
module nmsbd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input nmsbd_pkg::result_t  res
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res))
		else $error("result word changed while stalled");

	// an empty output stage never backpressures the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_box_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res.kept |-> res.right_x > res.left_x && res.bottom_y > res.top_y)
		else $error("kept box is empty");

	a_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !res.kept |-> res.frame_end && res.score == '0 && res.class_num == '0)
		else $error("result without detection is not a clean frame end");

endmodule

bind nms_by_class_box_decoder nmsbd_checker u_nmsbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in.ready),
	.out_valid (out.valid),
	.out_ready (out.ready),
	.res       (out.res)
);

FILE: tb/tb_nms_by_class_box_decoder.sv
module tb_nms_by_class_box_decoder;
	import nmsbd_pkg::*;

	localparam int ONE          = 1 << FRAC_BITS;
	localparam int ONE_HALF_X3  = 3 * ONE / 2;
	localparam int SCORE_POS    = WORDS_PER_BOX - 1;
	localparam int SIZE_REG_MAX = (1 << SIZE_W) - 1;
	localparam int RANDOM_WORDS = 1000;
	localparam int SAT_BOXES    = 24;
	localparam int SETTLE_CYCLES = 6;
	localparam longint CYCLE_LIMIT = 250000;
	localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_EVERY_THIRD, RDY_COIN} ready_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	nmsbd_word_if   word_ch ();
	nmsbd_result_if res_ch ();

	nms_by_class_box_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(word_ch),
		.out(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// mirror of the block's registers and parse state
	logic [SIZE_W-1:0]        width_reg, height_reg, limit_reg;
	logic [CLASS_W-1:0]       classes_reg;
	logic [CLASS_W-1:0]       cur_class;
	bit                       want_count;
	int                       boxes_rem, field_idx;
	logic signed [WORD_W-1:0] held [COORD_N];

	result_t pending_results[$];
	int      fail_count = 0;
	int      burst_left = 0;
	longint  cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic longint to_pix(logic signed [WORD_W-1:0] w, logic [SIZE_W-1:0] size_reg);
		longint sz, p, wl;
		sz = size_reg;
		if (sz > MAX_SIZE)
			sz = MAX_SIZE;
		wl = w;
		// normalized coords (<= 1.5) scale by the size, larger ones are pixels already
		if (wl <= ONE_HALF_X3)
			p = (wl * sz) / ONE;
		else
			p = wl / ONE;
		if (p > sz - 1)
			p = sz - 1;
		if (p < 0)
			p = 0;
		return p;
	endfunction

	function automatic bit close_class();
		logic [CLASS_W-1:0] total;
		total = (classes_reg == '0) ? CLASS_W'(1) : classes_reg;
		cur_class = cur_class + 1'b1;
		want_count = 1'b1;
		boxes_rem = 0;
		field_idx = 0;
		if (cur_class >= total) begin
			cur_class = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void decode_word(logic signed [WORD_W-1:0] w);
		result_t            r;
		bit                 hit, last;
		longint             wl, cnt, y1, x1, y2, x2;
		logic [CLASS_W-1:0] cls;
		r = '0;
		hit = 1'b0;
		last = 1'b0;
		cls = cur_class;
		wl = w;
		y1 = 0;
		x1 = 0;
		y2 = 0;
		x2 = 0;
		if (want_count) begin
			cnt = (wl > 0) ? (wl >>> FRAC_BITS) : 0;
			if (cnt > MAX_COUNT)
				cnt = MAX_COUNT;
			if (cnt == 0)
				last = close_class();
			else begin
				boxes_rem = int'(cnt);
				want_count = 1'b0;
				field_idx = 0;
			end
		end else if (field_idx < SCORE_POS) begin
			held[field_idx] = w;
			field_idx++;
		end else begin
			if (wl >= longint'(limit_reg)) begin
				y1 = to_pix(held[CRD_YMIN], height_reg);
				x1 = to_pix(held[CRD_XMIN], width_reg);
				y2 = to_pix(held[CRD_YMAX], height_reg);
				x2 = to_pix(held[CRD_XMAX], width_reg);
				hit = !(x2 <= x1 || y2 <= y1);
			end
			field_idx = 0;
			if (boxes_rem > 0)
				boxes_rem--;
			if (boxes_rem == 0)
				last = close_class();
		end
		if (hit) begin
			r.kept = 1'b1;
			r.class_num = cls;
			r.left_x = x1[PIX_W-1:0];
			r.top_y = y1[PIX_W-1:0];
			r.right_x = x2[PIX_W-1:0];
			r.bottom_y = y2[PIX_W-1:0];
			r.score = w;
		end
		r.frame_end = last;
		if (hit || last)
			pending_results = {pending_results, r};
	endfunction

	function automatic void check_field(string name, logic [WORD_W-1:0] exp_v,
			logic [WORD_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want, got;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got = res_ch.res;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result expected none, got %h", $time, got);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kept", want.kept, got.kept);
				check_field("class_num", want.class_num, got.class_num);
				check_field("left_x", want.left_x, got.left_x);
				check_field("top_y", want.top_y, got.top_y);
				check_field("right_x", want.right_x, got.right_x);
				check_field("bottom_y", want.bottom_y, got.bottom_y);
				check_field("score", want.score, got.score);
				check_field("frame_end", want.frame_end, got.frame_end);
			end
		end
	end

	// result side back-pressure, switching between patterns
	initial begin : ready_gen
		ready_mode_t mode;
		int          left, tick;
		res_ch.ready <= 1'b0;
		mode = RDY_ALWAYS;
		left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = ready_mode_t'($urandom_range(0, 3));
				left = $urandom_range(30, 200);
			end else
				left--;
			tick++;
			case (mode)
				RDY_ALWAYS: res_ch.ready <= 1'b1;
				RDY_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
				RDY_EVERY_THIRD: res_ch.ready <= (tick % 3 == 0);
				default: res_ch.ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	task automatic send_word(logic signed [WORD_W-1:0] w);
		int gap;
		word_ch.valid <= 1'b1;
		word_ch.word <= w;
		do
			@(posedge clk);
		while (word_ch.ready !== 1'b1);
		decode_word(w);
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
			gap = $urandom_range(1, 8);
			word_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		word_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// a word with no result may still be in the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_TARGET_WIDTH: width_reg = val;
			CFG_TARGET_HEIGHT: height_reg = val;
			CFG_SCORE_LIMIT: limit_reg = val;
			CFG_CLASS_TOTAL: classes_reg = val[CLASS_W-1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
			logic [SIZE_W-1:0] lim, logic [CFG_DATA_W-1:0] cls);
		wait_idle();
		write_reg(CFG_TARGET_WIDTH, w);
		write_reg(CFG_TARGET_HEIGHT, h);
		write_reg(CFG_SCORE_LIMIT, lim);
		write_reg(CFG_CLASS_TOTAL, cls);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [WORD_W-1:0] rand_coord();
		logic signed [WORD_W-1:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c = WORD_W'($urandom_range(0, ONE_HALF_X3));
			4, 5: c = WORD_W'($urandom_range(ONE_HALF_X3 + 1, WORD_MAX));
			6: c = WORD_W'(-int'($urandom_range(1, 1 << (WORD_W - 1))));
			7: begin
				case ($urandom_range(0, 5))
					0: c = '0;
					1: c = WORD_W'(ONE_HALF_X3);
					2: c = WORD_W'(ONE_HALF_X3 + 1);
					3: c = '1;
					4: c = WORD_MAX;
					default: c = WORD_MIN;
				endcase
			end
			default: c = WORD_W'($urandom);
		endcase
		return c;
	endfunction

	function automatic logic signed [WORD_W-1:0] rand_score();
		int lim;
		lim = limit_reg;
		case ($urandom_range(0, 9))
			0: return WORD_W'(lim - 1);
			1: return WORD_W'(lim);
			2: return WORD_W'(lim + 1);
			3: return WORD_W'($urandom_range(0, lim));
			4: return WORD_W'($urandom);
			default: return WORD_W'($urandom_range(lim, WORD_MAX));
		endcase
	endfunction

	function automatic logic signed [WORD_W-1:0] rand_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return WORD_W'($urandom_range(0, ONE - 1));
		else if (r < 85)
			return WORD_W'(($urandom_range(1, 3) << FRAC_BITS) | $urandom_range(0, ONE - 1));
		else if (r < 95)
			return WORD_W'(-int'($urandom_range(1, 1 << (WORD_W - 1))));
		return WORD_W'(($urandom_range(4, 8) << FRAC_BITS) | $urandom_range(0, ONE - 1));
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return SIZE_W'(1);
			2: return SIZE_W'(2);
			3: return SIZE_W'(MAX_SIZE - 1);
			4: return MAX_SIZE_V;
			5: return SIZE_W'($urandom_range(MAX_SIZE + 1, SIZE_REG_MAX));
			6: return SIZE_W'(640);
			default: return SIZE_W'($urandom_range(1, MAX_SIZE));
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SIZE_W'(1);
			2: return SIZE_W'(ONE);
			3: return SIZE_W'(SIZE_REG_MAX);
			default: return SIZE_W'($urandom_range(0, ONE));
		endcase
	endfunction

	// upper data bits are outside the class total register and must be dropped
	function automatic logic [CFG_DATA_W-1:0] pick_classes();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return CFG_DATA_W'(MAX_COUNT);
			2, 3: return CFG_DATA_W'(($urandom_range(1, 31) << CLASS_W) | $urandom_range(0, 4));
			default: return CFG_DATA_W'($urandom_range(1, 4));
		endcase
	endfunction

	// one box, optionally cut short; coords mostly ordered so boxes survive
	task automatic send_box(int words);
		logic signed [WORD_W-1:0] f [WORDS_PER_BOX];
		logic signed [WORD_W-1:0] t;
		f[CRD_YMIN] = rand_coord();
		f[CRD_XMIN] = rand_coord();
		f[CRD_YMAX] = rand_coord();
		f[CRD_XMAX] = rand_coord();
		if ($urandom_range(0, 4) != 0) begin
			if (f[CRD_YMIN] > f[CRD_YMAX]) begin
				t = f[CRD_YMIN];
				f[CRD_YMIN] = f[CRD_YMAX];
				f[CRD_YMAX] = t;
			end
			if (f[CRD_XMIN] > f[CRD_XMAX]) begin
				t = f[CRD_XMIN];
				f[CRD_XMIN] = f[CRD_XMAX];
				f[CRD_XMAX] = t;
			end
		end
		f[SCORE_POS] = rand_score();
		for (int i = 0; i < words; i++)
			send_word(f[i]);
	endtask

	// reset register values: normalized box, pixel box at the score limit,
	// negative count and a fractional count below one
	task automatic test_default_decode();
		send_word(2 * ONE + 'h7FF);
		send_word(ONE / 10);
		send_word(ONE / 4);
		send_word(ONE / 2);
		send_word(ONE_HALF_X3);
		send_word(ONE);
		send_word(100 * ONE + 5);
		send_word(50 * ONE);
		send_word(300 * ONE);
		send_word(200 * ONE + ONE - 1);
		send_word(ONE / 2);
		send_word(-ONE);
		send_word(ONE - 1);
	endtask

	// kept box on the word that closes the frame, word extremes as coords
	task automatic test_frame_end_with_box();
		set_config(640, 640, ONE / 2, 4);
		send_word(ONE);
		send_word(WORD_MIN);
		send_word(0);
		send_word(WORD_MAX);
		send_word(ONE_HALF_X3 + 1);
		send_word(WORD_MAX);
	endtask

	// oversized width, zero height, zero class total, zero score limit
	task automatic test_size_extremes();
		set_config(SIZE_REG_MAX, 0, 0, 0);
		send_word(ONE);
		send_word(ONE / 2);
		send_word(ONE / 2);
		send_word(ONE);
		send_word(ONE);
		send_word(0);
	endtask

	task automatic test_random_frames();
		int sent_words, phase_left, n;
		sent_words = 0;
		phase_left = 0;
		while (sent_words < RANDOM_WORDS) begin
			if (phase_left == 0) begin
				set_config(pick_size(), pick_size(), pick_limit(), pick_classes());
				phase_left = $urandom_range(40, 160);
			end
			n = 1;
			if ($urandom_range(0, 11) == 0)
				send_word(WORD_W'($urandom));
			else if (want_count)
				send_word(rand_count());
			else if (field_idx == 0) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SCORE_POS) : WORDS_PER_BOX;
				send_box(n);
			end else
				send_word((field_idx == SCORE_POS) ? rand_score() : rand_coord());
			sent_words += n;
			phase_left = (phase_left > n) ? phase_left - n : 0;
		end
	endtask

	// a count of 256 saturates to 255 boxes instead of wrapping to zero, so
	// with one class no frame end follows the count or the boxes after it
	task automatic test_count_saturation();
		set_config(MAX_SIZE_V, MAX_SIZE_V, ONE, 1);
		while (!want_count)
			send_word((field_idx == SCORE_POS) ? rand_score() : rand_coord());
		send_word(256 * ONE);
		for (int b = 0; b < SAT_BOXES; b++)
			send_box(WORDS_PER_BOX);
	endtask

	initial begin
		word_ch.valid <= 1'b0;
		word_ch.word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		width_reg = 640;
		height_reg = 640;
		limit_reg = 2048;
		classes_reg = 80;
		cur_class = '0;
		want_count = 1'b1;
		boxes_rem = 0;
		field_idx = 0;
		foreach (held[i])
			held[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_decode();
		test_frame_end_with_box();
		test_size_extremes();
		test_random_frames();
		test_count_saturation();

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
